/* src/lcs_pkg.sv */
// ----------------------------------------------------------------------------
// lcs_pkg
// Shared types and codes for the longest common substring length unit.
// ----------------------------------------------------------------------------
package lcs_pkg;

    localparam int OUT_W  = 9;
    localparam int BYTE_W = 8;

    typedef enum logic [1:0] {
        MODE_APPEND  = 2'd0,
        MODE_COMPARE = 2'd1,
        MODE_CLEAR   = 2'd2
    } t_mode;

    typedef struct packed {
        logic [1:0]        mode;
        logic [BYTE_W-1:0] text_byte;
        logic              last_byte;
    } t_in_item;

    typedef struct packed {
        logic [OUT_W-1:0] longest_match;
        logic [OUT_W-1:0] reference_length;
        logic             overflowed;
    } t_out_item;

    // Broadcast from the controller to every cell of the row
    typedef struct packed {
        logic              append;
        logic              compare;
        logic              clr_all;
        logic              clr_runs;
        logic [BYTE_W-1:0] text_byte;
    } t_cell_ctl;

endpackage

/* src/lcs_cell.sv */
// ----------------------------------------------------------------------------
// lcs_cell
// One reference position: stored byte, running match length, local best,
// and one stage of the running-maximum chain.
// ----------------------------------------------------------------------------
module lcs_cell #(
    parameter int  MAX_TEXT = 256,
    localparam int RUN_W    = $clog2(MAX_TEXT + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lcs_pkg::t_cell_ctl i_ctl,
    input  logic              i_left_valid,
    input  logic [RUN_W-1:0]  i_left_run,
    input  logic [RUN_W-1:0]  i_left_max,
    output logic              o_valid,
    output logic [RUN_W-1:0]  o_run,
    output logic [RUN_W-1:0]  o_max
);
    import lcs_pkg::*;

    logic              r_valid;
    logic [BYTE_W-1:0] r_ref;
    logic [RUN_W-1:0]  r_run;
    logic [RUN_W-1:0]  r_best;
    logic [RUN_W-1:0]  r_max;
    logic [RUN_W-1:0]  n_run;
    logic [RUN_W-1:0]  n_best;
    logic              w_write;
    logic              w_hit;

    // Thermometer fill: the first empty cell after the last valid one takes the byte
    assign w_write = i_ctl.append & i_left_valid & ~r_valid;
    assign w_hit   = r_valid & (r_ref == i_ctl.text_byte);
    assign n_run   = w_hit ? (i_left_run + RUN_W'(1)) : '0;
    assign n_best  = (n_run > r_best) ? n_run : r_best;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_run   <= '0;
            r_best  <= '0;
            r_max   <= '0;
        end else begin
            if (i_ctl.clr_all) begin
                r_valid <= 1'b0;
                r_run   <= '0;
                r_best  <= '0;
            end else if (i_ctl.clr_runs) begin
                r_run   <= '0;
                r_best  <= '0;
            end else if (w_write) begin
                r_valid <= 1'b1;
                r_run   <= '0;
            end else if (i_ctl.compare) begin
                r_run   <= n_run;
                r_best  <= n_best;
            end
            r_max <= (r_best > i_left_max) ? r_best : i_left_max;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_write) begin
            r_ref <= i_ctl.text_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_run   = r_run;
    assign o_max   = r_max;

endmodule

/* src/lcs_ctrl.sv */
// ----------------------------------------------------------------------------
// lcs_ctrl
// Decodes transactions, tracks the reference length and overflow, and waits
// for the maximum to ripple down the cell row before issuing the result.
// ----------------------------------------------------------------------------
module lcs_ctrl #(
    parameter int  MAX_TEXT = 256,
    localparam int RUN_W    = $clog2(MAX_TEXT + 1)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  lcs_pkg::t_in_item  i_item,
    input  logic [RUN_W-1:0]   i_chain_max,
    output logic               o_busy,
    output lcs_pkg::t_cell_ctl o_ctl,
    output lcs_pkg::t_out_item o_result,
    output logic               o_done
);
    import lcs_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'b01,
        ST_DRAIN = 2'b10
    } t_state;

    localparam logic [RUN_W-1:0] DRAIN_END = RUN_W'(MAX_TEXT);

    t_state           r_state;
    t_state           n_state;
    logic [RUN_W-1:0] r_count;
    logic [RUN_W-1:0] r_drain;
    logic             r_ovf;
    logic             r_done;
    t_out_item        r_result;
    logic             w_accept;
    logic             w_append;
    logic             w_compare;
    logic             w_clear;
    logic             w_full;
    logic             w_drain_end;

    assign w_accept    = i_start & r_state[1'b0];
    assign w_append    = w_accept & (i_item.mode == MODE_APPEND);
    assign w_compare   = w_accept & (i_item.mode == MODE_COMPARE);
    assign w_clear     = w_accept & (i_item.mode == MODE_CLEAR);
    assign w_full      = (r_count == RUN_W'(MAX_TEXT));
    assign w_drain_end = r_state[1] & (r_drain == DRAIN_END);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_compare && i_item.last_byte) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (w_drain_end) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_drain <= '0;
            r_ovf   <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= w_drain_end;
            if (r_state[1]) begin
                r_drain <= r_drain + RUN_W'(1);
            end else begin
                r_drain <= '0;
            end
            if (w_clear) begin
                r_count <= '0;
                r_ovf   <= 1'b0;
            end else if (w_append) begin
                if (w_full) begin
                    r_ovf   <= 1'b1;
                end else begin
                    r_count <= r_count + RUN_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_drain_end) begin
            r_result.longest_match    <= OUT_W'(i_chain_max);
            r_result.reference_length <= OUT_W'(r_count);
            r_result.overflowed       <= r_ovf;
        end
    end

    assign o_ctl.append    = w_append;
    assign o_ctl.compare   = w_compare;
    assign o_ctl.clr_all   = w_clear;
    assign o_ctl.clr_runs  = w_drain_end;
    assign o_ctl.text_byte = i_item.text_byte;

    assign o_busy   = r_state[1];
    assign o_result = r_result;
    assign o_done   = r_done;

endmodule

/* src/longest_common_substring_length_unit.sv */
// ----------------------------------------------------------------------------
// longest_common_substring_length_unit
// Longest common substring length between a stored reference and a stream.
// ----------------------------------------------------------------------------
// Append, clear and compare transactions are taken one per clock while busy
// is low. A compare transaction with last_byte set raises busy while the
// running maximum shifts down the row of MAX_TEXT cells, one cell per
// cycle; the result appears with o_done for one cycle as busy falls. The
// receiver cannot stall: o_result is valid only while o_done is high.
// References longer than MAX_TEXT are truncated and flagged as overflowed.
module longest_common_substring_length_unit #(
    parameter int MAX_TEXT = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  lcs_pkg::t_in_item  i_item,
    output logic               busy,
    output lcs_pkg::t_out_item o_result,
    output logic               o_done
);
    import lcs_pkg::*;

    localparam int RUN_W = $clog2(MAX_TEXT + 1);

    t_cell_ctl        w_ctl;
    logic             w_valid [MAX_TEXT];
    logic [RUN_W-1:0] w_run   [MAX_TEXT];
    logic [RUN_W-1:0] w_max   [MAX_TEXT];

    lcs_ctrl #(
        .MAX_TEXT(MAX_TEXT)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_item     (i_item),
        .i_chain_max(w_max[MAX_TEXT-1]),
        .o_busy     (busy),
        .o_ctl      (w_ctl),
        .o_result   (o_result),
        .o_done     (o_done)
    );

    for (genvar g = 0; g < MAX_TEXT; g++) begin : g_cell
        if (g == 0) begin : g_head
            lcs_cell #(
                .MAX_TEXT(MAX_TEXT)
            ) u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_ctl       (w_ctl),
                .i_left_valid(1'b1),
                .i_left_run  ('0),
                .i_left_max  ('0),
                .o_valid     (w_valid[g]),
                .o_run       (w_run[g]),
                .o_max       (w_max[g])
            );
        end else begin : g_body
            lcs_cell #(
                .MAX_TEXT(MAX_TEXT)
            ) u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_ctl       (w_ctl),
                .i_left_valid(w_valid[g-1]),
                .i_left_run  (w_run[g-1]),
                .i_left_max  (w_max[g-1]),
                .o_valid     (w_valid[g]),
                .o_run       (w_run[g]),
                .o_max       (w_max[g])
            );
        end
    end

endmodule

/* src/lcs_checker.sv */
// ----------------------------------------------------------------------------
// lcs_checker
// Port-level checks on the transaction and result timing of the unit.
// ----------------------------------------------------------------------------
module lcs_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input lcs_pkg::t_in_item  i_item,
    input logic               busy,
    input logic               o_done
);
    import lcs_pkg::*;

    logic w_last_accept;

    assign w_last_accept = start & ~busy & (i_item.mode == MODE_COMPARE) & i_item.last_byte;

    // Final compare byte starts the drain
    a_last_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_last_accept |=> busy)
        else $error("busy not raised after final compare byte");

    // Result shows only once the unit is free again
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while busy");

    // Every end of drain carries a result
    a_fall_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_done)
        else $error("drain ended without result");

    // A result is never repeated
    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe longer than one cycle");

    // Results only follow a drain
    a_done_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy))
        else $error("result without a final compare byte");

endmodule

bind longest_common_substring_length_unit lcs_checker u_lcs_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .i_item  (i_item),
    .busy    (busy),
    .o_done  (o_done)
);

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for longest_common_substring_length_unit.
// ----------------------------------------------------------------------------
// Sends reference, compare, clear and unused-mode transactions in random
// bursts. A behavioral tracker mirrors the row of running match lengths and
// queues the expected result of each final compare byte. A checker process
// compares every o_done result against the oldest queued entry.
module tb;
    import lcs_pkg::*;

    localparam int MAX_TEXT       = 256;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int ITEM_TARGET    = 2000;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    logic      i_clk;
    logic      i_rst_n;
    logic      start;
    t_in_item  i_item;
    logic      busy;
    t_out_item o_result;
    logic      o_done;

    longest_common_substring_length_unit #(.MAX_TEXT(MAX_TEXT)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_item  (i_item),
        .busy    (busy),
        .o_result(o_result),
        .o_done  (o_done)
    );

    // Tracker state
    logic [7:0]  ref_bytes [MAX_TEXT];
    int unsigned run_len   [MAX_TEXT];
    int unsigned best_len;
    int unsigned ref_count;
    logic        ref_overflow;

    t_out_item expected_results[$];
    int        error_count;
    int        items_sent;
    int        burst_left;
    int        stall_cycles;

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    function automatic t_in_item make_item(logic [1:0] mode, logic [7:0] b, logic last);
        t_in_item it;
        it.mode      = mode;
        it.text_byte = b;
        it.last_byte = last;
        return it;
    endfunction

    function automatic void clear_runs();
        foreach (run_len[i]) run_len[i] = 0;
        best_len = 0;
    endfunction

    // Mirrors the effect of one accepted transaction and queues its result
    function automatic void track_item(t_in_item it);
        t_out_item res;
        int unsigned v;
        case (it.mode)
            MODE_APPEND: begin
                if (ref_count < MAX_TEXT) begin
                    ref_bytes[ref_count] = it.text_byte;
                    run_len[ref_count]   = 0;
                    ref_count++;
                end else begin
                    ref_overflow = 1'b1;
                end
            end
            MODE_CLEAR: begin
                ref_count    = 0;
                ref_overflow = 1'b0;
                clear_runs();
            end
            MODE_COMPARE: begin
                // descend so each cell sees its left neighbor's old length
                for (int p = int'(ref_count) - 1; p >= 0; p--) begin
                    v = 0;
                    if (ref_bytes[p] == it.text_byte)
                        v = ((p > 0) ? run_len[p-1] : 0) + 1;
                    run_len[p] = v;
                    if (v > best_len) best_len = v;
                end
                if (it.last_byte) begin
                    res.longest_match    = best_len[8:0];
                    res.reference_length = ref_count[8:0];
                    res.overflowed       = ref_overflow;
                    expected_results.push_back(res);
                    clear_runs();
                end
            end
            default: ;
        endcase
    endfunction

    // Drives one transaction and holds it until the unit takes it
    task automatic send_item(t_in_item it);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 6);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
            burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 30);
        end
        start  <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy);
        burst_left--;
        track_item(it);
        if (it.mode != MODE_UNUSED) items_sent++;
    endtask

    // Result checker: o_done and o_result are sampled before the edge updates
    always @(posedge i_clk) begin
        t_out_item exp_res;
        if (i_rst_n && o_done) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result: expected none, actual %0d/%0d/%0d",
                         $time, o_result.longest_match, o_result.reference_length,
                         o_result.overflowed);
                error_count++;
            end else begin
                exp_res = expected_results.pop_front();
                if (o_result.longest_match !== exp_res.longest_match) begin
                    $display("%0t: longest_match mismatch: expected %0d, actual %0d",
                             $time, exp_res.longest_match, o_result.longest_match);
                    error_count++;
                end
                if (o_result.reference_length !== exp_res.reference_length) begin
                    $display("%0t: reference_length mismatch: expected %0d, actual %0d",
                             $time, exp_res.reference_length, o_result.reference_length);
                    error_count++;
                end
                if (o_result.overflowed !== exp_res.overflowed) begin
                    $display("%0t: overflowed mismatch: expected %0d, actual %0d",
                             $time, exp_res.overflowed, o_result.overflowed);
                    error_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_done) stall_cycles <= 0;
        else stall_cycles <= stall_cycles + 1;
    end

    initial begin
        do @(posedge i_clk); while (stall_cycles < WATCHDOG_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    task automatic test_directed();
        send_item(make_item(MODE_CLEAR, 8'hFF, 1'b1));        // last ignored on clear
        send_item(make_item(MODE_COMPARE, 8'h00, 1'b1));      // empty reference
        send_item(make_item(MODE_APPEND, 8'h00, 1'b0));
        send_item(make_item(MODE_APPEND, 8'hFF, 1'b1));       // last ignored on append
        send_item(make_item(MODE_APPEND, 8'hAA, 1'b0));
        send_item(make_item(MODE_APPEND, 8'h55, 1'b0));
        send_item(make_item(MODE_COMPARE, 8'hFF, 1'b0));
        send_item(make_item(MODE_COMPARE, 8'hAA, 1'b1));
        send_item(make_item(MODE_UNUSED, 8'hFF, 1'b1));       // ignored
        send_item(make_item(MODE_COMPARE, 8'h55, 1'b0));
        send_item(make_item(MODE_APPEND, 8'h01, 1'b0));       // append mid-comparison
        send_item(make_item(MODE_COMPARE, 8'h01, 1'b0));
        send_item(make_item(MODE_COMPARE, 8'h02, 1'b1));
        send_item(make_item(MODE_COMPARE, 8'h00, 1'b0));
        send_item(make_item(MODE_COMPARE, 8'hFF, 1'b0));
        send_item(make_item(MODE_COMPARE, 8'hAA, 1'b0));
        send_item(make_item(MODE_COMPARE, 8'h55, 1'b0));
        send_item(make_item(MODE_COMPARE, 8'h01, 1'b1));
        send_item(make_item(MODE_CLEAR, 8'h00, 1'b0));
        send_item(make_item(MODE_COMPARE, 8'h55, 1'b1));
    endtask

    // Fill the store to capacity, overflow it, then match the whole reference
    task automatic test_full_reference();
        logic [7:0] txt [MAX_TEXT];
        send_item(make_item(MODE_CLEAR, 8'h00, 1'b0));
        foreach (txt[i]) begin
            txt[i] = 8'($urandom);
            send_item(make_item(MODE_APPEND, txt[i], 1'b0));
        end
        repeat (3) send_item(make_item(MODE_APPEND, 8'($urandom), 1'b0));
        foreach (txt[i]) send_item(make_item(MODE_COMPARE, txt[i], i == MAX_TEXT - 1));
        send_item(make_item(MODE_COMPARE, txt[7], 1'b1));
        send_item(make_item(MODE_CLEAR, 8'h00, 1'b0));
        send_item(make_item(MODE_COMPARE, txt[0], 1'b1));
    endtask

    // One session: optional clear, a reference, then a few second texts
    task automatic random_session();
        logic [7:0] ref_txt[$];
        logic [7:0] base;
        logic [7:0] b;
        int ref_len;
        int txt_len;
        int num_texts;
        int pos;
        bit wide;
        base = 8'($urandom);
        wide = ($urandom_range(0, 7) == 0);
        if ($urandom_range(0, 3) != 0)
            send_item(make_item(MODE_CLEAR, 8'($urandom), 1'($urandom)));
        ref_len = ($urandom_range(0, 19) == 0) ? $urandom_range(200, 262)
                                               : $urandom_range(1, 24);
        for (int i = 0; i < ref_len; i++) begin
            b = wide ? 8'($urandom) : base ^ 8'($urandom_range(0, 3));
            ref_txt.push_back(b);
            send_item(make_item(MODE_APPEND, b, 1'($urandom)));
        end
        num_texts = $urandom_range(1, 3);
        for (int t = 0; t < num_texts; t++) begin
            txt_len = $urandom_range(1, 24);
            pos = $urandom_range(0, ref_txt.size() - 1);
            for (int i = 0; i < txt_len; i++) begin
                case ($urandom_range(0, 39))
                    0: send_item(make_item(MODE_UNUSED, 8'($urandom), 1'($urandom)));
                    1: send_item(make_item(MODE_APPEND, base ^ 8'($urandom_range(0, 3)),
                                           1'($urandom)));
                    default: ;
                endcase
                if ($urandom_range(0, 1) == 0 && $urandom_range(0, 9) != 0)
                    b = ref_txt[(pos + i) % ref_txt.size()];
                else
                    b = wide ? 8'($urandom) : base ^ 8'($urandom_range(0, 3));
                // occasionally leave a text unterminated
                send_item(make_item(MODE_COMPARE, b,
                                    i == txt_len - 1 && $urandom_range(0, 19) != 0));
            end
        end
    endtask

    task automatic test_random();
        while (items_sent < ITEM_TARGET) random_session();
        send_item(make_item(MODE_COMPARE, 8'($urandom), 1'b1));
    endtask

    initial begin
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_item       = '0;
        error_count  = 0;
        items_sent   = 0;
        burst_left   = 0;
        stall_cycles = 0;
        ref_count    = 0;
        ref_overflow = 1'b0;
        foreach (ref_bytes[i]) ref_bytes[i] = '0;
        clear_runs();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_full_reference();
        test_random();

        start <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (MAX_TEXT + 4) @(posedge i_clk);
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

/* files.f */
src/lcs_pkg.sv
src/lcs_cell.sv
src/lcs_ctrl.sv
src/longest_common_substring_length_unit.sv
src/lcs_checker.sv
tb/tb.sv
